[rtl/sawc_pkg.sv]
// Shared codes and constants for the set-associative write-back cache.
package sawc_pkg;

    localparam int unsigned SETS_DEF       = 64;
    localparam int unsigned WAYS_DEF       = 4;
    localparam int unsigned LINE_WORDS_DEF = 16;

    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hffff;

    localparam logic [31:0] RAM_BASE_RST = 32'h8000_0000;
    localparam logic [31:0] WIN_SIZE_RST = 32'h0800_0000;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_CLEAN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_READ_DATA = 2'd0,
        KIND_WRITE_OK  = 2'd1,
        KIND_FILL_REQ  = 2'd2,
        KIND_WRITEBACK = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_WINDOW = 2'd1,
        FAULT_CROSS  = 2'd2,
        FAULT_RSVD   = 2'd3
    } fault_t;

    localparam logic REG_RAM_BASE = 1'b0;
    localparam logic REG_WIN_SIZE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

endpackage

[rtl/set_assoc_writeback_cache.sv]
// Set-associative write-back data cache with least-frequently-used replacement.
//
// Requests enter on the s_ stream: s_tuser carries the command (read, write,
// fill word, clean set), s_tdata the address, data and size. Results leave on
// the m_ stream, one transfer each; m_tlast marks the final result of a request.
// ram_base and win_size are set through the cfg_ write port; the user must write
// them only while idle, as the block does not enforce it. One request is worked
// at a time; s_tready is high only between requests. Tags and use counters sit
// in per-set row memories, line words in a one-word data memory, all with
// registered reads. A hit runs tag row read, decode, two word reads, merge and
// a second write for a write that spans two words. A fill word is written in
// decode; the last one then completes the held access in the same steps as a hit.
// A miss runs tag row read, decode and the fill request, plus a read and an output
// per written-back word of a dirty victim; a clean is decode plus the same per word.
// A stalled m_tready holds the pending result and stalls each state that emits one.
// Reset clears valid and dirty bits, the pending miss and the output valid bit;
// tag, counter and data memories are not cleared, as valid bits gate them.
// SETS and LINE_WORDS must be powers of two.
module set_assoc_writeback_cache #(
    parameter int unsigned SETS       = sawc_pkg::SETS_DEF,
    parameter int unsigned WAYS       = sawc_pkg::WAYS_DEF,
    parameter int unsigned LINE_WORDS = sawc_pkg::LINE_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // address[31:0], data[63:32], size[65:64], zero pad
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // mem_address[31:0], value[63:32]
    output logic [3:0]  m_tuser,   // kind[1:0], fault[3:2]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import sawc_pkg::*;

    localparam int unsigned LINE_BYTES = LINE_WORDS * 4;
    localparam int unsigned LINES      = SETS * WAYS;
    localparam int unsigned OFF_W      = $clog2(LINE_BYTES);
    localparam int unsigned SET_W      = $clog2(SETS);
    localparam int unsigned TAG_W      = 32 - OFF_W - SET_W;
    localparam int unsigned SET_IW     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned WI_W       = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
    localparam int unsigned LINE_IW    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int unsigned DA_W       = (LINES * LINE_WORDS > 1) ?
                                         $clog2(LINES * LINE_WORDS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_WB_RD, S_WB_OUT, S_REQ, S_ACC0, S_ACC1, S_ACC2, S_ACC3
    } state_t;

    typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;
    typedef logic [WAYS-1:0][CNT_W-1:0] cnt_row_t;

    // memories
    tag_row_t    tag_mem [SETS];
    cnt_row_t    cnt_mem [SETS];
    logic [31:0] data_mem [LINES * LINE_WORDS];

    tag_row_t    tag_row_q;
    cnt_row_t    cnt_row_q;
    logic [31:0] dm_q;

    logic              tag_we, cnt_we, dm_we, dm_re;
    tag_row_t          tag_wrow;
    cnt_row_t          cnt_wrow;
    logic [SET_IW-1:0] row_raddr;
    logic [DA_W-1:0]   dm_waddr, dm_raddr;
    logic [31:0]       dm_wdata;

    // control registers
    state_t             state_reg;
    logic [31:0]        ram_base_reg, win_size_reg;
    logic [LINES-1:0]   valid_reg, dirty_reg;
    logic               pend_reg;
    logic [1:0]         pend_cmd_reg, pend_size_reg;
    logic [31:0]        pend_addr_reg, pend_data_reg;
    logic [WI_W-1:0]    fill_cnt_reg;
    logic [WAY_W-1:0]   victim_reg;
    logic [1:0]         cmd_reg, size_reg;
    logic [31:0]        addr_reg, data_reg;
    logic [SET_IW-1:0]  set_reg;
    logic [WAY_W-1:0]   way_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [WAYS-1:0]    wb_mask_reg;
    logic               wb_clean_reg;
    logic [WI_W-1:0]    wb_idx_reg;
    logic [31:0]        w0_reg;

    logic               m_valid_reg, m_last_reg;
    logic [1:0]         m_kind_reg, m_fault_reg;
    logic [31:0]        m_addr_reg, m_value_reg;

    function automatic logic [SET_IW-1:0] set_of(input logic [31:0] a);
        return SET_IW'((a >> OFF_W) % SETS);
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
        return TAG_W'(a >> (OFF_W + SET_W));
    endfunction

    function automatic logic [LINE_IW-1:0] line_of(input logic [SET_IW-1:0] s,
                                                   input logic [WAY_W-1:0] w);
        return LINE_IW'(32'(s) * WAYS + 32'(w));
    endfunction

    function automatic logic [DA_W-1:0] da_of(input logic [SET_IW-1:0] s,
                                              input logic [WAY_W-1:0] w,
                                              input logic [WI_W-1:0] i);
        return DA_W'(32'(line_of(s, w)) * LINE_WORDS + 32'(i));
    endfunction

    // decode of the held request
    logic [OFF_W-1:0]  off;
    logic [2:0]        nbytes;
    logic              cross_line, cross_word;
    logic [TAG_W-1:0]  req_tag;
    logic [WAYS-1:0]   hit_vec, dirty_vec;
    logic              hit_any;
    logic [WAY_W-1:0]  hit_way, pick_way, next_wb_way;
    logic              pick_found;
    logic [CNT_W:0]    best;
    logic              win_ok;
    logic [32:0]       line_base33, win_hi33;
    logic [WI_W-1:0]   a_idx, b_idx;
    logic [31:0]       byte_mask;
    logic [63:0]       pair, new_pair;
    logic [5:0]        bsh;
    logic [31:0]       rd_value;
    logic [WAYS-1:0]   wb_rest;
    logic              out_free;
    logic [CNT_W-1:0]  hit_cnt_next;

    assign off        = addr_reg[OFF_W-1:0];
    assign nbytes     = (size_reg == SIZE_BYTE) ? 3'd1 : ((size_reg == SIZE_HALF) ? 3'd2 : 3'd4);
    assign cross_line = (32'(off) + 32'(nbytes)) > LINE_BYTES;
    assign cross_word = (3'(off[1:0]) + nbytes) > 3'd4;
    assign req_tag    = tag_of(addr_reg);
    assign a_idx      = WI_W'(off >> 2);
    assign b_idx      = (32'(a_idx) == LINE_WORDS - 1) ? a_idx : WI_W'(32'(a_idx) + 1);
    assign byte_mask  = (size_reg == SIZE_BYTE) ? 32'h0000_00ff :
                        ((size_reg == SIZE_HALF) ? 32'h0000_ffff : 32'hffff_ffff);
    assign bsh        = {1'b0, off[1:0], 3'b000};
    assign pair       = {dm_q, w0_reg};
    assign rd_value   = 32'(pair >> bsh) & byte_mask;
    assign new_pair   = (pair & ~({32'h0, byte_mask} << bsh)) |
                        ({32'h0, data_reg & byte_mask} << bsh);
    assign line_base33 = {1'b0, addr_reg & ~32'(LINE_BYTES - 1)};
    assign win_hi33    = {1'b0, ram_base_reg} + {1'b0, win_size_reg};
    assign win_ok      = (line_base33 >= {1'b0, ram_base_reg}) &&
                         (line_base33 + 33'(LINE_BYTES) <= win_hi33);
    assign out_free    = !m_valid_reg || m_tready;
    assign wb_rest     = wb_mask_reg & ~(WAYS'(1) << way_reg);

    always_comb
    begin
        hit_any    = 1'b0;
        hit_way    = '0;
        pick_found = 1'b0;
        pick_way   = '0;
        best       = (CNT_W+1)'(CNT_MAX) + 1'b1;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w]   = valid_reg[line_of(set_reg, WAY_W'(w))] &&
                           (tag_row_q[w] == req_tag);
            dirty_vec[w] = valid_reg[line_of(set_reg, WAY_W'(w))] &&
                           dirty_reg[line_of(set_reg, WAY_W'(w))];
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (!pick_found)
            begin
                if (!valid_reg[line_of(set_reg, WAY_W'(w))])
                begin
                    pick_way   = WAY_W'(w);
                    pick_found = 1'b1;
                end
                else if ({1'b0, cnt_row_q[w]} < best)
                begin
                    best     = {1'b0, cnt_row_q[w]};
                    pick_way = WAY_W'(w);
                end
            end
        end
        next_wb_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (wb_rest[w])
            begin
                next_wb_way = WAY_W'(w);
            end
        end
        hit_cnt_next = (cnt_row_q[hit_way] == CNT_MAX) ? CNT_MAX : cnt_row_q[hit_way] + 1'b1;
    end

    logic [WAY_W-1:0] first_dirty;
    always_comb
    begin
        first_dirty = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (dirty_vec[w])
            begin
                first_dirty = WAY_W'(w);
            end
        end
    end

    // memory port controls
    always_comb
    begin
        tag_we   = 1'b0;
        cnt_we   = 1'b0;
        dm_we    = 1'b0;
        dm_re    = 1'b0;
        tag_wrow = tag_row_q;
        cnt_wrow = cnt_row_q;
        dm_waddr = da_of(set_reg, way_reg, a_idx);
        dm_raddr = da_of(set_reg, way_reg, a_idx);
        dm_wdata = new_pair[31:0];
        row_raddr = set_reg;
        if (state_reg == S_IDLE)
        begin
            unique case (cmd_t'(s_tuser))
                CMD_FILL:  row_raddr = set_of(pend_addr_reg);
                CMD_CLEAN: row_raddr = SET_IW'(s_tdata[31:0] % SETS);
                default:   row_raddr = set_of(s_tdata[31:0]);
            endcase
        end
        unique case (state_reg)
            S_DECODE:
            begin
                if (cmd_reg == CMD_FILL && pend_reg)
                begin
                    dm_we    = 1'b1;
                    dm_waddr = da_of(set_reg, victim_reg, fill_cnt_reg);
                    dm_wdata = data_reg;
                    if (32'(fill_cnt_reg) == LINE_WORDS - 1)
                    begin
                        tag_we = 1'b1;
                        cnt_we = 1'b1;
                        tag_wrow[victim_reg] = tag_of(pend_addr_reg);
                        cnt_wrow[victim_reg] = CNT_W'(2);
                    end
                end
                else if ((cmd_reg == CMD_READ || cmd_reg == CMD_WRITE) && !pend_reg &&
                         !cross_line && hit_any)
                begin
                    cnt_we = 1'b1;
                    cnt_wrow[hit_way] = hit_cnt_next;
                end
            end
            S_WB_RD:
            begin
                dm_re    = 1'b1;
                dm_raddr = da_of(set_reg, way_reg, wb_idx_reg);
            end
            S_ACC0:
            begin
                dm_re = 1'b1;
            end
            S_ACC1:
            begin
                dm_re    = 1'b1;
                dm_raddr = da_of(set_reg, way_reg, b_idx);
            end
            S_ACC2:
            begin
                dm_we = (cmd_reg == CMD_WRITE) && out_free;
            end
            S_ACC3:
            begin
                dm_we    = 1'b1;
                dm_waddr = da_of(set_reg, way_reg, b_idx);
                dm_wdata = new_pair[63:32];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        tag_row_q <= tag_mem[row_raddr];
        cnt_row_q <= cnt_mem[row_raddr];
        if (tag_we)
        begin
            tag_mem[set_reg] <= tag_wrow;
        end
        if (cnt_we)
        begin
            cnt_mem[set_reg] <= cnt_wrow;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dm_re)
        begin
            dm_q <= data_mem[dm_raddr];
        end
        if (dm_we)
        begin
            data_mem[dm_waddr] <= dm_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_base_reg <= RAM_BASE_RST;
            win_size_reg <= WIN_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RAM_BASE: ram_base_reg <= cfg_data;
                REG_WIN_SIZE: win_size_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            pend_reg     <= 1'b0;
            fill_cnt_reg <= '0;
            victim_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg   <= s_tuser;
                        addr_reg  <= s_tdata[31:0];
                        data_reg  <= s_tdata[63:32];
                        size_reg  <= s_tdata[65:64];
                        set_reg   <= row_raddr;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    unique case (cmd_t'(cmd_reg))
                        CMD_FILL:
                        begin
                            if (!pend_reg)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else if (32'(fill_cnt_reg) == LINE_WORDS - 1)
                            begin
                                fill_cnt_reg <= '0;
                                pend_reg     <= 1'b0;
                                valid_reg[line_of(set_reg, victim_reg)] <= 1'b1;
                                dirty_reg[line_of(set_reg, victim_reg)] <=
                                    (pend_cmd_reg == CMD_WRITE);
                                cmd_reg   <= pend_cmd_reg;
                                addr_reg  <= pend_addr_reg;
                                data_reg  <= pend_data_reg;
                                size_reg  <= pend_size_reg;
                                way_reg   <= victim_reg;
                                state_reg <= S_ACC0;
                            end
                            else
                            begin
                                fill_cnt_reg <= fill_cnt_reg + 1'b1;
                                state_reg    <= S_IDLE;
                            end
                        end
                        CMD_CLEAN:
                        begin
                            if (dirty_vec == '0)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                wb_mask_reg  <= dirty_vec;
                                wb_clean_reg <= 1'b1;
                                way_reg      <= first_dirty;
                                tag_reg      <= tag_row_q[first_dirty];
                                wb_idx_reg   <= '0;
                                state_reg    <= S_WB_RD;
                            end
                        end
                        default:
                        begin
                            if (pend_reg)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else if (cross_line || (!hit_any && !win_ok))
                            begin
                                if (out_free)
                                begin
                                    m_valid_reg <= 1'b1;
                                    m_kind_reg  <= cmd_reg;
                                    m_addr_reg  <= '0;
                                    m_value_reg <= '0;
                                    m_fault_reg <= cross_line ? FAULT_CROSS : FAULT_WINDOW;
                                    m_last_reg  <= 1'b1;
                                    state_reg   <= S_IDLE;
                                end
                            end
                            else if (hit_any)
                            begin
                                if (cmd_reg == CMD_WRITE)
                                begin
                                    dirty_reg[line_of(set_reg, hit_way)] <= 1'b1;
                                end
                                way_reg   <= hit_way;
                                state_reg <= S_ACC0;
                            end
                            else
                            begin
                                valid_reg[line_of(set_reg, pick_way)] <= 1'b0;
                                dirty_reg[line_of(set_reg, pick_way)] <= 1'b0;
                                victim_reg    <= pick_way;
                                way_reg       <= pick_way;
                                fill_cnt_reg  <= '0;
                                pend_reg      <= 1'b1;
                                pend_cmd_reg  <= cmd_reg;
                                pend_addr_reg <= addr_reg;
                                pend_data_reg <= data_reg;
                                pend_size_reg <= size_reg;
                                tag_reg       <= tag_row_q[pick_way];
                                wb_mask_reg   <= '0;
                                wb_clean_reg  <= 1'b0;
                                wb_idx_reg    <= '0;
                                state_reg     <= dirty_vec[pick_way] ? S_WB_RD : S_REQ;
                            end
                        end
                    endcase
                end
                S_WB_RD:
                begin
                    state_reg <= S_WB_OUT;
                end
                S_WB_OUT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KIND_WRITEBACK;
                        m_addr_reg  <= (32'(tag_reg) << (SET_W + OFF_W)) |
                                       (32'(set_reg) << OFF_W) | (32'(wb_idx_reg) << 2);
                        m_value_reg <= dm_q;
                        m_fault_reg <= FAULT_NONE;
                        m_last_reg  <= wb_clean_reg && (32'(wb_idx_reg) == LINE_WORDS - 1) &&
                                       (wb_rest == '0);
                        if (32'(wb_idx_reg) == LINE_WORDS - 1)
                        begin
                            wb_idx_reg <= '0;
                            if (!wb_clean_reg)
                            begin
                                state_reg <= S_REQ;
                            end
                            else
                            begin
                                dirty_reg[line_of(set_reg, way_reg)] <= 1'b0;
                                wb_mask_reg <= wb_rest;
                                way_reg     <= next_wb_way;
                                tag_reg     <= tag_row_q[next_wb_way];
                                state_reg   <= (wb_rest == '0) ? S_IDLE : S_WB_RD;
                            end
                        end
                        else
                        begin
                            wb_idx_reg <= wb_idx_reg + 1'b1;
                            state_reg  <= S_WB_RD;
                        end
                    end
                end
                S_REQ:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KIND_FILL_REQ;
                        m_addr_reg  <= line_base33[31:0];
                        m_value_reg <= '0;
                        m_fault_reg <= FAULT_NONE;
                        m_last_reg  <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_ACC0:
                begin
                    state_reg <= S_ACC1;
                end
                S_ACC1:
                begin
                    w0_reg    <= dm_q;
                    state_reg <= S_ACC2;
                end
                S_ACC2:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_addr_reg  <= '0;
                        m_fault_reg <= FAULT_NONE;
                        m_last_reg  <= 1'b1;
                        if (cmd_reg == CMD_WRITE)
                        begin
                            m_kind_reg  <= KIND_WRITE_OK;
                            m_value_reg <= '0;
                            state_reg   <= cross_word ? S_ACC3 : S_IDLE;
                        end
                        else
                        begin
                            m_kind_reg  <= KIND_READ_DATA;
                            m_value_reg <= rd_value;
                            state_reg   <= S_IDLE;
                        end
                    end
                end
                S_ACC3:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_value_reg, m_addr_reg};
    assign m_tuser  = {m_fault_reg, m_kind_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg |-> (fill_cnt_reg == '0))
        else $error("fill count nonzero with no miss pending");

    a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE && cmd_reg == CMD_FILL && pend_reg &&
         32'(fill_cnt_reg) == LINE_WORDS - 1) |=> !pend_reg)
        else $error("miss still pending after last fill word");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_DECODE))
        else $error("accepted transfer not decoded");

    a_req_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_kind_reg == KIND_FILL_REQ) |-> m_last_reg)
        else $error("fill request not marked last");
`endif

endmodule

[tb/sv/set_assoc_writeback_cache_tb.sv]
// Self-checking testbench for the set-associative write-back cache.
module set_assoc_writeback_cache_tb;
    import sawc_pkg::*;

    localparam int NSETS = int'(SETS_DEF);
    localparam int NWAYS = int'(WAYS_DEF);
    localparam int LWORDS = int'(LINE_WORDS_DEF);
    localparam int LBYTES = LWORDS * 4;
    localparam int NLINES = NSETS * NWAYS;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] address;
        logic [31:0] data;
        logic [1:0]  size;
    } access_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] mem_address;
        logic [31:0] value;
        fault_t      fault;
        logic        last;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    set_assoc_writeback_cache u_top (.*);

    // cache shadow
    logic [31:0] base_reg, size_reg;
    logic [31:0] tags [NLINES];
    logic        valids [NLINES];
    logic        dirtys [NLINES];
    logic [15:0] uses [NLINES];
    logic [31:0] words [NLINES*LWORDS];
    logic        miss_busy;
    access_t     miss_acc;
    int          fill_idx;
    int          victim;

    access_t pending_items[$];
    result_t expected_results[$];
    int      errors;
    longint  cycles;
    int      results_seen;
    int      hold_off;
    bit      sender_pause;
    bit      drive_done;

    task automatic report(input string what, input result_t got, input result_t want);
        errors++;
        $display("mismatch %s: got k%0d a%h v%h f%0d l%0b want k%0d a%h v%h f%0d l%0b",
                 what, got.kind, got.mem_address, got.value, got.fault, got.last,
                 want.kind, want.mem_address, want.value, want.fault, want.last);
    endtask

    function automatic void push_result(kind_t k, logic [31:0] a, logic [31:0] v,
                                        fault_t f, logic l);
        result_t r;
        r.kind = k; r.mem_address = a; r.value = v; r.fault = f; r.last = l;
        expected_results.push_back(r);
    endfunction

    function automatic int nbytes(logic [1:0] sz);
        return sz == 0 ? 1 : (sz == 1 ? 2 : 4);
    endfunction

    function automatic void line_hit(int ln, int off, access_t a);
        int n;
        logic [31:0] v;
        int idx;
        n = nbytes(a.size);
        v = 0;
        if (uses[ln] != CNT_MAX)
            uses[ln]++;
        for (int i = 0; i < n; i++)
        begin
            idx = ln * LWORDS + (off + i) / 4;
            if (a.cmd == CMD_WRITE)
                words[idx][((off+i)%4)*8 +: 8] = a.data[8*i +: 8];
            else
                v[8*i +: 8] = words[idx][((off+i)%4)*8 +: 8];
        end
        if (a.cmd == CMD_WRITE)
        begin
            dirtys[ln] = 1;
            push_result(KIND_WRITE_OK, 0, 0, FAULT_NONE, 1);
        end
        else
            push_result(KIND_READ_DATA, 0, v, FAULT_NONE, 1);
    endfunction

    function automatic void evict_words(int st, int ln);
        logic [31:0] b;
        b = (tags[ln] * NSETS + st) * LBYTES;
        for (int i = 0; i < LWORDS; i++)
            push_result(KIND_WRITEBACK, b + 4*i, words[ln*LWORDS+i], FAULT_NONE, 0);
    endfunction

    function automatic void predict_cache(access_t a);
        int st, ln, off, pick, best, n0;
        logic [31:0] tg, lbase;
        longint hi;
        bit found;
        if (a.cmd == CMD_FILL)
        begin
            if (!miss_busy)
                return;
            st = (miss_acc.address / LBYTES) % NSETS;
            ln = st * NWAYS + victim;
            words[ln*LWORDS + fill_idx] = a.data;
            fill_idx++;
            if (fill_idx < LWORDS)
                return;
            fill_idx = 0;
            miss_busy = 0;
            tags[ln] = miss_acc.address / (LBYTES * NSETS);
            valids[ln] = 1;
            dirtys[ln] = 0;
            uses[ln] = 1;
            line_hit(ln, miss_acc.address % LBYTES, miss_acc);
            return;
        end
        if (a.cmd == CMD_CLEAN)
        begin
            st = a.address % NSETS;
            n0 = expected_results.size();
            for (int w = 0; w < NWAYS; w++)
            begin
                ln = st * NWAYS + w;
                if (valids[ln] && dirtys[ln])
                begin
                    evict_words(st, ln);
                    dirtys[ln] = 0;
                end
            end
            if (expected_results.size() > n0)
                expected_results[expected_results.size()-1].last = 1;
            return;
        end
        if (miss_busy)
            return;
        off = a.address % LBYTES;
        if (off + nbytes(a.size) > LBYTES)
        begin
            push_result(kind_t'(a.cmd), 0, 0, FAULT_CROSS, 1);
            return;
        end
        st = (a.address / LBYTES) % NSETS;
        tg = a.address / (LBYTES * NSETS);
        for (int w = 0; w < NWAYS; w++)
        begin
            ln = st * NWAYS + w;
            if (valids[ln] && tags[ln] == tg)
            begin
                line_hit(ln, off, a);
                return;
            end
        end
        lbase = a.address - off;
        hi = longint'(base_reg) + longint'(size_reg);
        if (!(lbase >= base_reg && longint'(lbase) + LBYTES <= hi))
        begin
            push_result(kind_t'(a.cmd), 0, 0, FAULT_WINDOW, 1);
            return;
        end
        pick = 0; best = 32'h10000; found = 0;
        for (int w = 0; w < NWAYS && !found; w++)
        begin
            ln = st * NWAYS + w;
            if (!valids[ln])
            begin
                pick = w; found = 1;
            end
            else if (uses[ln] < best)
            begin
                best = uses[ln]; pick = w;
            end
        end
        ln = st * NWAYS + pick;
        if (valids[ln] && dirtys[ln])
            evict_words(st, ln);
        valids[ln] = 0;
        dirtys[ln] = 0;
        victim = pick;
        fill_idx = 0;
        miss_busy = 1;
        miss_acc = a;
        push_result(KIND_FILL_REQ, lbase, 0, FAULT_NONE, 1);
    endfunction

    function automatic access_t mk(cmd_t c, logic [31:0] a, logic [31:0] d, logic [1:0] s);
        access_t x;
        x.cmd = c; x.address = a; x.data = d; x.size = s;
        return x;
    endfunction

    function automatic void queue_fills(int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back(mk(CMD_FILL, $urandom, $urandom,
                                       2'($urandom_range(0, 3))));
    endfunction

    // address just above base, stepping over eight tags and four lines
    function automatic logic [31:0] window_addr();
        logic [31:0] a;
        a = base_reg + ($urandom_range(0, 7) * LBYTES * NSETS)
            + ($urandom_range(0, 3) * LBYTES) + $urandom_range(0, LBYTES - 1);
        return a;
    endfunction

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // long receiver hold-off, counted down on its own
    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // driver
    int gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata <= 0;
            s_tuser <= 0;
            gap <= 0;
        end
        else if (s_tvalid && !s_tready)
        begin
        end
        else
        begin
            if (s_tvalid)
                predict_cache(mk(cmd_t'(s_tuser), s_tdata[31:0], s_tdata[63:32],
                                 s_tdata[65:64]));
            if (gap > 0 || sender_pause || pending_items.size() == 0)
            begin
                s_tvalid <= 0;
                if (gap > 0)
                    gap <= gap - 1;
                drive_done <= pending_items.size() == 0;
            end
            else
            begin
                access_t x;
                x = pending_items.pop_front();
                s_tvalid <= 1;
                s_tuser <= x.cmd;
                s_tdata <= {6'd0, x.size, x.data, x.address};
                gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                drive_done <= 0;
            end
        end
    end

    // monitor
    int stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 0;
            stall <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_t got, want;
                got.kind = kind_t'(m_tuser[1:0]);
                got.fault = fault_t'(m_tuser[3:2]);
                got.mem_address = m_tdata[31:0];
                got.value = m_tdata[63:32];
                got.last = m_tlast;
                results_seen++;
                if (expected_results.size() == 0)
                    report("unexpected", got, got);
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        report("field", got, want);
                end
            end
            if (hold_off > 0)
            begin
                m_tready <= 0;
            end
            else if (stall > 0)
            begin
                m_tready <= 0;
                stall <= stall - 1;
            end
            else if (m_tvalid && m_tready || !m_tready)
            begin
                int d;
                d = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
                m_tready <= d == 0;
                stall <= d;
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || !drive_done || s_tvalid
               || expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == REG_RAM_BASE)
            base_reg = v;
        else
            size_reg = v;
    endtask

    // n random items: accesses near base, some with fills; cleans; others
    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 19);
            if (r < 12)
            begin
                pending_items.push_back(mk(cmd_t'($urandom_range(0, 1)), window_addr(),
                                           $urandom, 2'($urandom_range(0, 3))));
                queue_fills(LWORDS);
            end
            else if (r < 17)
                pending_items.push_back(mk(cmd_t'($urandom_range(0, 1)), window_addr(),
                                           $urandom, 2'($urandom_range(0, 3))));
            else if (r < 18)
                pending_items.push_back(mk(CMD_CLEAN, $urandom, $urandom,
                                           2'($urandom_range(0, 3))));
            else
                pending_items.push_back(mk(cmd_t'($urandom_range(0, 3)), $urandom,
                                           $urandom, 2'($urandom_range(0, 3))));
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        errors = 0;
        cycles = 0;
        results_seen = 0;
        hold_off = 0;
        sender_pause = 0;
        drive_done = 0;
        base_reg = RAM_BASE_RST;
        size_reg = WIN_SIZE_RST;
        miss_busy = 0;
        fill_idx = 0;
        victim = 0;
        for (int i = 0; i < NLINES; i++)
        begin
            valids[i] = 0; dirtys[i] = 0; uses[i] = 0; tags[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1;

        // directed: reset window, faults, extremes, all sizes
        pending_items.push_back(mk(CMD_FILL, 32'hffffffff, 32'hffffffff, 2'd3));
        pending_items.push_back(mk(CMD_CLEAN, 32'h0, 0, 0));
        pending_items.push_back(mk(CMD_READ, 32'h0, 0, 2'd2));
        pending_items.push_back(mk(CMD_WRITE, 32'hffffffff, 32'hffffffff, 2'd0));
        pending_items.push_back(mk(CMD_READ, 32'h8000003f, 0, 2'd1));
        pending_items.push_back(mk(CMD_WRITE, 32'h8000003e, 0, 2'd3));
        pending_items.push_back(mk(CMD_WRITE, 32'h87ffffc0, 32'hffffffff, 2'd2));
        queue_fills(LWORDS);
        pending_items.push_back(mk(CMD_READ, 32'h87ffffc1, 0, 2'd2));
        pending_items.push_back(mk(CMD_WRITE, 32'h87ffffc5, 32'h0000a55a, 2'd1));
        pending_items.push_back(mk(CMD_READ, 32'h87ffffc2, 0, 2'd0));
        pending_items.push_back(mk(CMD_CLEAN, 32'hffffffff, 0, 0));
        pending_items.push_back(mk(CMD_CLEAN, 32'hffffffff, 0, 0));
        pending_items.push_back(mk(CMD_READ, 32'h80000000, 0, 2'd0));
        pending_items.push_back(mk(CMD_READ, 32'h80000004, 0, 2'd0));
        queue_fills(LWORDS);
        wait_drained();

        // receiver holds off while sender keeps offering
        hold_off = 300;
        random_phase(6);
        wait_drained();

        write_reg(REG_RAM_BASE, 32'h0);
        write_reg(REG_WIN_SIZE, 32'hffffffff);
        random_phase(4);
        while (pending_items.size() > 8)
            @(posedge clk);
        // sender pauses until every expected result is back
        sender_pause = 1;
        while (s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        sender_pause = 0;
        random_phase(4);
        wait_drained();

        write_reg(REG_RAM_BASE, 32'hffff0000);
        write_reg(REG_WIN_SIZE, 32'hffffffff);
        random_phase(5);
        wait_drained();

        write_reg(REG_RAM_BASE, 32'h40000000);
        write_reg(REG_WIN_SIZE, 32'h0);
        random_phase(1);
        wait_drained();

        write_reg(REG_RAM_BASE, 32'h10000000);
        write_reg(REG_WIN_SIZE, 32'h00010000);
        random_phase(4);
        for (int s = 0; s < NSETS; s++)
            pending_items.push_back(mk(CMD_CLEAN, s, 0, 0));
        wait_drained();

        $display("covered hits, misses with eviction, fills, cleans and both faults;");
        $display("%0d results checked over %0d cycles", results_seen, cycles);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
